[design/swss_pkg.sv]
// ----------------------------------------------------------------------------
// swss_pkg - shared types and constants of the send scoreboard
// Field widths, operation codes, sequencer states and the request format of
// the shared compare unit.
// ----------------------------------------------------------------------------
package swss_pkg;

  localparam int SEQ_W         = 32;
  localparam int TIME_W        = 32;
  localparam int LEN_W         = 11;
  localparam int WIN_W         = 16;
  localparam int TMO_W         = 16;
  localparam int SLOT_OUT_W    = 3;
  localparam int ALU_W         = 32;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd20;
  localparam logic [SEQ_W-1:0] SEQ_RESET     = 32'd1;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ACK   = 2'd1,
    OP_OFFER = 2'd2,
    OP_END   = 2'd3
  } swss_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK_RD,
    ST_ACK_EV,
    ST_OFFER_SCAN,
    ST_RTX_RD,
    ST_RTX_EV,
    ST_FILL_RD,
    ST_FILL_EV,
    ST_STATUS
  } swss_state_t;

  // Modes of the shared add and compare unit.
  typedef enum logic [1:0] {
    ALU_ADD_LE,
    ALU_SUB_GE,
    ALU_ADD_GT
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t         mode;
    logic [ALU_W-1:0]  a;
    logic [ALU_W-1:0]  b;
    logic [ALU_W-1:0]  c;
  } alu_req_t;

endpackage

[design/sliding_window_send_scoreboard_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_send_scoreboard_unit - transmit scoreboard, cumulative ACK
// Tracks a window of segment slots, frees them on cumulative ACKs, stages
// offered chunks and issues send and retransmit commands.
// ----------------------------------------------------------------------------
// Each input item is a tick, a cumulative ACK, an offered chunk or an end of
// data mark. The unit answers it with zero or more send commands, timeouts
// first and then new segments in slot order within the advertised window,
// followed by one closing status item flagged by out_last. Items are handled
// one at a time: in_stall is high from the accept until the status item has
// been loaded into the output register. Each item runs the retransmit pass,
// the fill pass and the status item, after the ACK scan or the offer scan
// where it calls for one. The retransmit pass reads and judges in-flight
// slots and the fill pass staged slots; the fill pass ends early at the
// first staged slot that does not fit the window. Output stalls lengthen an
// item. The time an item takes is set by the single registered read port
// of the slot memories, visited one slot at a time, and by the one shared
// add and compare unit that judges each visited slot.
// ----------------------------------------------------------------------------
module sliding_window_send_scoreboard_unit
  import swss_pkg::*;
#(
  parameter int WINDOW_SLOTS = 8,
  parameter int MAX_SEGMENT  = 1024,
  parameter int RECV_WINDOW  = 65535
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [TMO_W-1:0]      cfg_wr_data,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [SEQ_W-1:0]      in_ack_number,
  input  logic [WIN_W-1:0]      in_window_advert,
  input  logic [LEN_W-1:0]      in_chunk_length,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_send,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  output logic [SEQ_W-1:0]      out_segment_seq,
  output logic [LEN_W-1:0]      out_segment_length,
  output logic                  out_is_retransmit,
  output logic                  out_chunk_accepted,
  output logic [WIN_W-1:0]      out_bytes_in_flight,
  output logic                  out_all_done,
  output logic                  out_last
);

  // Slot index width and the width of the in-flight byte count, which must
  // hold every slot at the largest possible length.
  localparam int IDX_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int INFL_W = $clog2(WINDOW_SLOTS * ((1 << LEN_W) - 1) + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);

  // Sequencer and per-slot status bits.
  swss_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [WINDOW_SLOTS-1:0] occ_r, occ_nxt;
  logic [WINDOW_SLOTS-1:0] sent_r, sent_nxt;

  // Scoreboard state.
  logic [TIME_W-1:0]       cur_time_r, cur_time_nxt;
  logic [SEQ_W-1:0]        tail_seq_r, tail_seq_nxt;
  logic [WIN_W-1:0]        window_r, window_nxt;
  logic                    data_ended_r, data_ended_nxt;
  logic [TMO_W-1:0]        timeout_r, timeout_nxt;

  // Per-item working registers.
  logic [SEQ_W-1:0]        ack_r, ack_nxt;
  logic [LEN_W-1:0]        clen_r, clen_nxt;
  logic                    accepted_r, accepted_nxt;
  logic [INFL_W-1:0]       inflight_r, inflight_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic                    is_send_r, is_send_nxt;
  logic [SLOT_OUT_W-1:0]   slot_r, slot_nxt;
  logic [SEQ_W-1:0]        seg_seq_r, seg_seq_nxt;
  logic [LEN_W-1:0]        seg_len_r, seg_len_nxt;
  logic                    retx_r, retx_nxt;
  logic                    acc_r, acc_nxt;
  logic [WIN_W-1:0]        infl_out_r, infl_out_nxt;
  logic                    done_r, done_nxt;
  logic                    last_r, last_nxt;

  // Slot memory read data, always for slot idx_r in the cycle after it is set.
  logic [SEQ_W-1:0]        seq_rd;
  logic [LEN_W-1:0]        len_rd;
  logic [TIME_W-1:0]       time_rd;

  // Helpers.
  logic                    in_fire;
  logic                    can_emit;
  logic                    last_slot;
  logic                    occ_bit;
  logic                    sent_bit;
  logic                    hit;
  alu_req_t                alu_req;
  logic [LEN_W-1:0]        clen_clamped;

  // Control from the sequencer's output decode.
  logic                    load_item;
  logic                    idx_adv;
  logic                    idx_zero;
  logic                    stage;
  logic                    clr_slot;
  logic                    set_sent;
  logic                    wr_time;
  logic                    add_infl;
  logic                    emit_rtx;
  logic                    emit_new;
  logic                    emit_stat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign can_emit  = !out_valid_r || !out_stall;
  assign last_slot = (idx_r == LAST_IDX);
  assign occ_bit   = occ_r[idx_r];
  assign sent_bit  = sent_r[idx_r];

  // Offered lengths above the segment limit are clamped to it.
  assign clen_clamped = ({{(TMO_W-LEN_W){1'b0}}, in_chunk_length} > TMO_W'(MAX_SEGMENT))
                        ? LEN_W'(MAX_SEGMENT) : in_chunk_length;

  // Slot memories. All writes go to the slot under the scan index.
  swss_ram #(.WIDTH(SEQ_W), .DEPTH(WINDOW_SLOTS)) u_seq_ram (
    .clk   (clk),
    .we    (stage),
    .waddr (idx_r),
    .wdata (tail_seq_r),
    .raddr (idx_r),
    .rdata (seq_rd)
  );

  swss_ram #(.WIDTH(LEN_W), .DEPTH(WINDOW_SLOTS)) u_len_ram (
    .clk   (clk),
    .we    (stage),
    .waddr (idx_r),
    .wdata (clen_r),
    .raddr (idx_r),
    .rdata (len_rd)
  );

  swss_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW_SLOTS)) u_time_ram (
    .clk   (clk),
    .we    (stage || wr_time),
    .waddr (idx_r),
    .wdata (cur_time_r),
    .raddr (idx_r),
    .rdata (time_rd)
  );

  // The shared compare unit: the ACK free test, the timeout test and the
  // window test each take their turn depending on the pass.
  always_comb begin
    alu_req.mode = ALU_ADD_LE;
    alu_req.a    = seq_rd;
    alu_req.b    = {{(ALU_W-LEN_W){1'b0}}, len_rd};
    alu_req.c    = ack_r;
    case (state_r)
      ST_RTX_EV: begin
        alu_req.mode = ALU_SUB_GE;
        alu_req.a    = cur_time_r;
        alu_req.b    = time_rd;
        alu_req.c    = {{(ALU_W-TMO_W){1'b0}}, timeout_r};
      end
      ST_FILL_EV: begin
        alu_req.mode = ALU_ADD_GT;
        alu_req.a    = ALU_W'(inflight_r);
        alu_req.c    = {{(ALU_W-WIN_W){1'b0}}, window_r};
      end
      default: begin
      end
    endcase
  end

  swss_alu u_alu (
    .req (alu_req),
    .hit (hit)
  );

  // Next state. An ACK scans for freed slots and an offer scans for the
  // lowest empty slot; every item then runs the retransmit pass, the fill
  // pass and the status item.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (swss_op_t'(in_operation))
            OP_ACK:   state_nxt = ST_ACK_RD;
            OP_OFFER: state_nxt = ((in_chunk_length != '0) && !data_ended_r)
                                  ? ST_OFFER_SCAN : ST_RTX_RD;
            default:  state_nxt = ST_RTX_RD;
          endcase
        end
      end
      ST_ACK_RD: begin
        if (occ_bit) begin
          state_nxt = ST_ACK_EV;
        end else if (last_slot) begin
          state_nxt = ST_RTX_RD;
        end
      end
      ST_ACK_EV: begin
        state_nxt = last_slot ? ST_RTX_RD : ST_ACK_RD;
      end
      ST_OFFER_SCAN: begin
        if (!occ_bit || last_slot) begin
          state_nxt = ST_RTX_RD;
        end
      end
      ST_RTX_RD: begin
        if (occ_bit && sent_bit) begin
          state_nxt = ST_RTX_EV;
        end else if (last_slot) begin
          state_nxt = ST_FILL_RD;
        end
      end
      ST_RTX_EV: begin
        if (!hit || can_emit) begin
          state_nxt = last_slot ? ST_FILL_RD : ST_RTX_RD;
        end
      end
      ST_FILL_RD: begin
        if (occ_bit && !sent_bit) begin
          state_nxt = ST_FILL_EV;
        end else if (last_slot) begin
          state_nxt = ST_STATUS;
        end
      end
      ST_FILL_EV: begin
        if (hit) begin
          state_nxt = ST_STATUS;
        end else if (can_emit) begin
          state_nxt = last_slot ? ST_STATUS : ST_FILL_RD;
        end
      end
      ST_STATUS: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    load_item = 1'b0;
    idx_adv   = 1'b0;
    idx_zero  = 1'b0;
    stage     = 1'b0;
    clr_slot  = 1'b0;
    set_sent  = 1'b0;
    wr_time   = 1'b0;
    add_infl  = 1'b0;
    emit_rtx  = 1'b0;
    emit_new  = 1'b0;
    emit_stat = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          load_item = 1'b1;
          idx_zero  = 1'b1;
        end
      end
      ST_ACK_RD: begin
        if (!occ_bit) begin
          idx_adv = 1'b1;
        end
      end
      ST_ACK_EV: begin
        idx_adv  = 1'b1;
        clr_slot = hit;
      end
      ST_OFFER_SCAN: begin
        if (!occ_bit) begin
          stage    = 1'b1;
          idx_zero = 1'b1;
        end else begin
          idx_adv = 1'b1;
        end
      end
      ST_RTX_RD: begin
        if (!(occ_bit && sent_bit)) begin
          idx_adv = 1'b1;
        end
      end
      ST_RTX_EV: begin
        if (!hit) begin
          add_infl = 1'b1;
          idx_adv  = 1'b1;
        end else if (can_emit) begin
          emit_rtx = 1'b1;
          wr_time  = 1'b1;
          add_infl = 1'b1;
          idx_adv  = 1'b1;
        end
      end
      ST_FILL_RD: begin
        if (!(occ_bit && !sent_bit)) begin
          idx_adv = 1'b1;
        end
      end
      ST_FILL_EV: begin
        if (hit) begin
          idx_zero = 1'b1;
        end else if (can_emit) begin
          emit_new = 1'b1;
          wr_time  = 1'b1;
          set_sent = 1'b1;
          add_infl = 1'b1;
          idx_adv  = 1'b1;
        end
      end
      ST_STATUS: begin
        emit_stat = can_emit;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    idx_nxt        = idx_r;
    occ_nxt        = occ_r;
    sent_nxt       = sent_r;
    cur_time_nxt   = cur_time_r;
    tail_seq_nxt   = tail_seq_r;
    window_nxt     = window_r;
    data_ended_nxt = data_ended_r;
    timeout_nxt    = cfg_wr_en ? cfg_wr_data : timeout_r;
    ack_nxt        = ack_r;
    clen_nxt       = clen_r;
    accepted_nxt   = accepted_r;
    inflight_nxt   = inflight_r;

    if (idx_zero) begin
      idx_nxt = '0;
    end else if (idx_adv) begin
      idx_nxt = last_slot ? '0 : idx_r + 1'b1;
    end

    if (load_item) begin
      ack_nxt      = in_ack_number;
      clen_nxt     = clen_clamped;
      accepted_nxt = 1'b0;
      inflight_nxt = '0;
      case (swss_op_t'(in_operation))
        OP_TICK: cur_time_nxt = cur_time_r + 1'b1;
        OP_ACK:  window_nxt   = in_window_advert;
        OP_OFFER: begin
          // A zero-length offer stands for end of data.
          if (in_chunk_length == '0) begin
            data_ended_nxt = 1'b1;
          end
        end
        OP_END:  data_ended_nxt = 1'b1;
        default: begin
        end
      endcase
    end

    if (stage) begin
      occ_nxt[idx_r]  = 1'b1;
      sent_nxt[idx_r] = 1'b0;
      tail_seq_nxt    = tail_seq_r + {{(SEQ_W-LEN_W){1'b0}}, clen_r};
      accepted_nxt    = 1'b1;
    end

    // Freeing drops staged slots as well as sent ones.
    if (clr_slot) begin
      occ_nxt[idx_r]  = 1'b0;
      sent_nxt[idx_r] = 1'b0;
    end

    if (set_sent) begin
      sent_nxt[idx_r] = 1'b1;
    end

    if (add_infl) begin
      inflight_nxt = inflight_r + INFL_W'(len_rd);
    end
  end

  // Output register: a finished item waits here while the next input item
  // may already be taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    is_send_nxt   = is_send_r;
    slot_nxt      = slot_r;
    seg_seq_nxt   = seg_seq_r;
    seg_len_nxt   = seg_len_r;
    retx_nxt      = retx_r;
    acc_nxt       = acc_r;
    infl_out_nxt  = infl_out_r;
    done_nxt      = done_r;
    last_nxt      = last_r;
    if (emit_rtx || emit_new) begin
      out_valid_nxt = 1'b1;
      is_send_nxt   = 1'b1;
      slot_nxt      = SLOT_OUT_W'(idx_r);
      seg_seq_nxt   = seq_rd;
      seg_len_nxt   = len_rd;
      retx_nxt      = emit_rtx;
      acc_nxt       = 1'b0;
      infl_out_nxt  = '0;
      done_nxt      = 1'b0;
      last_nxt      = 1'b0;
    end else if (emit_stat) begin
      out_valid_nxt = 1'b1;
      is_send_nxt   = 1'b0;
      slot_nxt      = '0;
      seg_seq_nxt   = '0;
      seg_len_nxt   = '0;
      retx_nxt      = 1'b0;
      acc_nxt       = accepted_r;
      infl_out_nxt  = WIN_W'(inflight_r);
      done_nxt      = data_ended_r && !(|occ_r);
      last_nxt      = 1'b1;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      occ_r        <= '0;
      sent_r       <= '0;
      cur_time_r   <= '0;
      tail_seq_r   <= SEQ_RESET;
      window_r     <= WIN_W'(RECV_WINDOW);
      data_ended_r <= 1'b0;
      timeout_r    <= TIMEOUT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      occ_r        <= occ_nxt;
      sent_r       <= sent_nxt;
      cur_time_r   <= cur_time_nxt;
      tail_seq_r   <= tail_seq_nxt;
      window_r     <= window_nxt;
      data_ended_r <= data_ended_nxt;
      timeout_r    <= timeout_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    ack_r      <= ack_nxt;
    clen_r     <= clen_nxt;
    accepted_r <= accepted_nxt;
    inflight_r <= inflight_nxt;
    is_send_r  <= is_send_nxt;
    slot_r     <= slot_nxt;
    seg_seq_r  <= seg_seq_nxt;
    seg_len_r  <= seg_len_nxt;
    retx_r     <= retx_nxt;
    acc_r      <= acc_nxt;
    infl_out_r <= infl_out_nxt;
    done_r     <= done_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_is_send         = is_send_r;
  assign out_slot_index      = slot_r;
  assign out_segment_seq     = seg_seq_r;
  assign out_segment_length  = seg_len_r;
  assign out_is_retransmit   = retx_r;
  assign out_chunk_accepted  = acc_r;
  assign out_bytes_in_flight = infl_out_r;
  assign out_all_done        = done_r;
  assign out_last            = last_r;

endmodule

[design/swss_ram.sv]
// ----------------------------------------------------------------------------
// swss_ram - generic single write, single read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module swss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/swss_alu.sv]
// ----------------------------------------------------------------------------
// swss_alu - shared add and compare unit
// Forms a + b or a - b at 32 bits and compares the result against c.
// ----------------------------------------------------------------------------
module swss_alu
  import swss_pkg::*;
(
  input  alu_req_t req,
  output logic     hit
);

  logic             sub;
  logic [ALU_W-1:0] opnd_b;
  logic [ALU_W-1:0] res;

  assign sub    = (req.mode == ALU_SUB_GE);
  assign opnd_b = sub ? ~req.b : req.b;
  assign res    = req.a + opnd_b + {{(ALU_W-1){1'b0}}, sub};

  always_comb begin
    case (req.mode)
      ALU_ADD_LE: hit = (res <= req.c);
      ALU_SUB_GE: hit = (res >= req.c);
      ALU_ADD_GT: hit = (res > req.c);
      default:    hit = 1'b0;
    endcase
  end

endmodule
